/* sv/ssot_pkg.sv */
`timescale 1ns / 1ps
// Package for the segment/sphere occlusion pipeline.
// Widths, word types and result codes; no dependencies.
package ssot_pkg;

  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int HALF_W     = SUM_W / 2;
  localparam int WIDE_W     = 2 * SUM_W;
  localparam int RADIUS_W   = 31;
  localparam int RSQ_W      = 2 * RADIUS_W;
  localparam int NUM_STAGES = 7;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(16840);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    CASE_ON_CLEAR    = 2'd0,
    CASE_ON_BLOCKED  = 2'd1,
    CASE_OFF_CLEAR   = 2'd2,
    CASE_OFF_INSIDE  = 2'd3
  } case_e;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t first_z;
    coord_t second_x;
    coord_t second_y;
    coord_t second_z;
  } in_word_t;

  typedef struct packed {
    logic  line_of_sight;
    case_e case_code;
  } out_word_t;

endpackage

/* sv/segment_sphere_occlusion_test.sv */
`timescale 1ns / 1ps
// Segment versus origin-centered sphere clearance test, seven-stage pipeline.
// Depends on ssot_pkg for widths, word types and result codes.

// Takes one pair of endpoints per cycle while in_stall_o is low and returns one
// result word per pair, in order. The stages follow the exact integer math:
// coordinate differences, the 32x32 squares and dot-product terms, their sums,
// the on-segment test, the wide den*(|p1|^2 - R^2) and num^2 products cut into
// half-width partial products, their recombination, and the final compare.
// Empty stages close up under a stall, so in_stall_o rises only when all seven
// stages hold a word.
// The radius register is written through the cfg port (always ready); write it
// only while no word is in flight.
module segment_sphere_occlusion_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ssot_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ssot_pkg::out_word_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssot_pkg::RADIUS_W-1:0]     cfg_data_i
);

  logic [ssot_pkg::RADIUS_W-1:0]   radius_q;
  logic [ssot_pkg::NUM_STAGES-1:0] vld_q;
  logic [ssot_pkg::NUM_STAGES-1:0] en;

  // stage 1
  logic [ssot_pkg::COORD_W-1:0] a_c [3];
  logic [ssot_pkg::COORD_W-1:0] b_c [3];
  logic [ssot_pkg::COORD_W-1:0] s1_amag_d [3], s1_amag_q [3];
  logic [ssot_pkg::COORD_W-1:0] s1_bmag_d [3], s1_bmag_q [3];
  logic [ssot_pkg::COORD_W-1:0] s1_dmag_d [3], s1_dmag_q [3];
  logic [2:0]                   s1_neg_d, s1_neg_q;

  // stage 2
  logic [ssot_pkg::PROD_W-1:0] s2_asq_d [3], s2_asq_q [3];
  logic [ssot_pkg::PROD_W-1:0] s2_bsq_d [3], s2_bsq_q [3];
  logic [ssot_pkg::PROD_W-1:0] s2_dsq_d [3], s2_dsq_q [3];
  logic [ssot_pkg::PROD_W-1:0] s2_ad_d [3],  s2_ad_q [3];
  logic [2:0]                  s2_neg_q;
  logic [ssot_pkg::RSQ_W-1:0]  s2_rsq_d, s2_rsq_q;

  // stage 3
  logic [ssot_pkg::SUM_W-1:0] s3_p1sq_d, s3_p1sq_q;
  logic [ssot_pkg::SUM_W-1:0] s3_p2sq_d, s3_p2sq_q;
  logic [ssot_pkg::SUM_W-1:0] s3_den_d,  s3_den_q;
  logic [ssot_pkg::SUM_W-1:0] s3_npos_d, s3_npos_q;
  logic [ssot_pkg::SUM_W-1:0] s3_nneg_d, s3_nneg_q;
  logic [ssot_pkg::RSQ_W-1:0] s3_rsq_q;

  // stage 4
  logic [ssot_pkg::SUM_W:0]   e_full, m_full;
  logic [ssot_pkg::SUM_W-1:0] rsq_ext;
  logic [ssot_pkg::SUM_W-1:0] s4_den_q;
  logic [ssot_pkg::SUM_W-1:0] s4_emag_d, s4_emag_q;
  logic [ssot_pkg::SUM_W-1:0] s4_mnum_d, s4_mnum_q;
  logic                       s4_eneg_d, s4_eneg_q;
  logic                       s4_onseg_d, s4_onseg_q;
  logic                       s4_out_d, s4_out_q;

  // stage 5
  logic [ssot_pkg::SUM_W-1:0] s5_pll_q, s5_plh_q, s5_phl_q, s5_phh_q;
  logic [ssot_pkg::SUM_W-1:0] s5_qll_q, s5_qlh_q, s5_qhh_q;
  logic                       s5_eneg_q, s5_onseg_q, s5_out_q;

  // stage 6
  logic [ssot_pkg::WIDE_W-1:0] s6_p_d, s6_p_q;
  logic [ssot_pkg::WIDE_W-1:0] s6_q_d, s6_q_q;
  logic                        s6_eneg_q, s6_onseg_q, s6_out_q;

  // stage 7
  logic                on_clear;
  ssot_pkg::out_word_t s7_out_d, s7_out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= ssot_pkg::RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[ssot_pkg::NUM_STAGES-1] = !vld_q[ssot_pkg::NUM_STAGES-1] || !out_stall_i;
    for (int k = ssot_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[ssot_pkg::NUM_STAGES-1];
  assign out_data_o  = s7_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < ssot_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 1: magnitudes of p1, p2 and d = p2 - p1
  assign a_c[0] = in_data_i.first_x;
  assign a_c[1] = in_data_i.first_y;
  assign a_c[2] = in_data_i.first_z;
  assign b_c[0] = in_data_i.second_x;
  assign b_c[1] = in_data_i.second_y;
  assign b_c[2] = in_data_i.second_z;

  always_comb begin
    logic [ssot_pkg::COORD_W:0] dfull;
    for (int k = 0; k < 3; k++) begin
      dfull = {b_c[k][ssot_pkg::COORD_W-1], b_c[k]} - {a_c[k][ssot_pkg::COORD_W-1], a_c[k]};
      s1_amag_d[k] = a_c[k][ssot_pkg::COORD_W-1] ? (~a_c[k] + 1'b1) : a_c[k];
      s1_bmag_d[k] = b_c[k][ssot_pkg::COORD_W-1] ? (~b_c[k] + 1'b1) : b_c[k];
      s1_dmag_d[k] = dfull[ssot_pkg::COORD_W]
                   ? ssot_pkg::COORD_W'(~dfull + 1'b1)
                   : dfull[ssot_pkg::COORD_W-1:0];
      s1_neg_d[k]  = a_c[k][ssot_pkg::COORD_W-1] ^ dfull[ssot_pkg::COORD_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_amag_q <= s1_amag_d;
      s1_bmag_q <= s1_bmag_d;
      s1_dmag_q <= s1_dmag_d;
      s1_neg_q  <= s1_neg_d;
    end
  end

  // stage 2: squares, dot-product terms and R^2
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_asq_d[k] = ssot_pkg::PROD_W'(s1_amag_q[k]) * ssot_pkg::PROD_W'(s1_amag_q[k]);
      s2_bsq_d[k] = ssot_pkg::PROD_W'(s1_bmag_q[k]) * ssot_pkg::PROD_W'(s1_bmag_q[k]);
      s2_dsq_d[k] = ssot_pkg::PROD_W'(s1_dmag_q[k]) * ssot_pkg::PROD_W'(s1_dmag_q[k]);
      s2_ad_d[k]  = ssot_pkg::PROD_W'(s1_amag_q[k]) * ssot_pkg::PROD_W'(s1_dmag_q[k]);
    end
    s2_rsq_d = ssot_pkg::RSQ_W'(radius_q) * ssot_pkg::RSQ_W'(radius_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_asq_q <= s2_asq_d;
      s2_bsq_q <= s2_bsq_d;
      s2_dsq_q <= s2_dsq_d;
      s2_ad_q  <= s2_ad_d;
      s2_neg_q <= s1_neg_q;
      s2_rsq_q <= s2_rsq_d;
    end
  end

  // stage 3: sums over the three axes
  always_comb begin
    s3_p1sq_d = '0;
    s3_p2sq_d = '0;
    s3_den_d  = '0;
    s3_npos_d = '0;
    s3_nneg_d = '0;
    for (int k = 0; k < 3; k++) begin
      s3_p1sq_d = s3_p1sq_d + ssot_pkg::SUM_W'(s2_asq_q[k]);
      s3_p2sq_d = s3_p2sq_d + ssot_pkg::SUM_W'(s2_bsq_q[k]);
      s3_den_d  = s3_den_d + ssot_pkg::SUM_W'(s2_dsq_q[k]);
      if (s2_neg_q[k]) begin
        s3_nneg_d = s3_nneg_d + ssot_pkg::SUM_W'(s2_ad_q[k]);
      end else begin
        s3_npos_d = s3_npos_d + ssot_pkg::SUM_W'(s2_ad_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_p1sq_q <= s3_p1sq_d;
      s3_p2sq_q <= s3_p2sq_d;
      s3_den_q  <= s3_den_d;
      s3_npos_q <= s3_npos_d;
      s3_nneg_q <= s3_nneg_d;
      s3_rsq_q  <= s2_rsq_q;
    end
  end

  // stage 4: on-segment test, -num and |p1|^2 - R^2
  always_comb begin
    rsq_ext    = ssot_pkg::SUM_W'(s3_rsq_q);
    e_full     = {1'b0, s3_p1sq_q} - {1'b0, rsq_ext};
    m_full     = {1'b0, s3_nneg_q} - {1'b0, s3_npos_q};
    s4_eneg_d  = e_full[ssot_pkg::SUM_W];
    s4_emag_d  = s4_eneg_d ? '0 : e_full[ssot_pkg::SUM_W-1:0];
    s4_mnum_d  = m_full[ssot_pkg::SUM_W-1:0];
    s4_onseg_d = (s3_den_q != '0) && !m_full[ssot_pkg::SUM_W] && (s4_mnum_d <= s3_den_q);
    s4_out_d   = (s3_p1sq_q > rsq_ext) && (s3_p2sq_q > rsq_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_den_q   <= s3_den_q;
      s4_emag_q  <= s4_emag_d;
      s4_mnum_q  <= s4_mnum_d;
      s4_eneg_q  <= s4_eneg_d;
      s4_onseg_q <= s4_onseg_d;
      s4_out_q   <= s4_out_d;
    end
  end

  // stage 5: half-width partial products of den*e and num^2
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_pll_q   <= ssot_pkg::SUM_W'(s4_den_q[ssot_pkg::HALF_W-1:0])
                  * ssot_pkg::SUM_W'(s4_emag_q[ssot_pkg::HALF_W-1:0]);
      s5_plh_q   <= ssot_pkg::SUM_W'(s4_den_q[ssot_pkg::HALF_W-1:0])
                  * ssot_pkg::SUM_W'(s4_emag_q[ssot_pkg::SUM_W-1:ssot_pkg::HALF_W]);
      s5_phl_q   <= ssot_pkg::SUM_W'(s4_den_q[ssot_pkg::SUM_W-1:ssot_pkg::HALF_W])
                  * ssot_pkg::SUM_W'(s4_emag_q[ssot_pkg::HALF_W-1:0]);
      s5_phh_q   <= ssot_pkg::SUM_W'(s4_den_q[ssot_pkg::SUM_W-1:ssot_pkg::HALF_W])
                  * ssot_pkg::SUM_W'(s4_emag_q[ssot_pkg::SUM_W-1:ssot_pkg::HALF_W]);
      s5_qll_q   <= ssot_pkg::SUM_W'(s4_mnum_q[ssot_pkg::HALF_W-1:0])
                  * ssot_pkg::SUM_W'(s4_mnum_q[ssot_pkg::HALF_W-1:0]);
      s5_qlh_q   <= ssot_pkg::SUM_W'(s4_mnum_q[ssot_pkg::HALF_W-1:0])
                  * ssot_pkg::SUM_W'(s4_mnum_q[ssot_pkg::SUM_W-1:ssot_pkg::HALF_W]);
      s5_qhh_q   <= ssot_pkg::SUM_W'(s4_mnum_q[ssot_pkg::SUM_W-1:ssot_pkg::HALF_W])
                  * ssot_pkg::SUM_W'(s4_mnum_q[ssot_pkg::SUM_W-1:ssot_pkg::HALF_W]);
      s5_eneg_q  <= s4_eneg_q;
      s5_onseg_q <= s4_onseg_q;
      s5_out_q   <= s4_out_q;
    end
  end

  // stage 6: recombine partial products
  always_comb begin
    s6_p_d = {s5_phh_q, s5_pll_q}
           + ((ssot_pkg::WIDE_W'(s5_plh_q) + ssot_pkg::WIDE_W'(s5_phl_q)) << ssot_pkg::HALF_W);
    s6_q_d = {s5_qhh_q, s5_qll_q}
           + (ssot_pkg::WIDE_W'(s5_qlh_q) << (ssot_pkg::HALF_W + 1));
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_p_q     <= s6_p_d;
      s6_q_q     <= s6_q_d;
      s6_eneg_q  <= s5_eneg_q;
      s6_onseg_q <= s5_onseg_q;
      s6_out_q   <= s5_out_q;
    end
  end

  // stage 7: final compare and result word
  always_comb begin
    on_clear = !s6_eneg_q && (s6_p_q >= s6_q_q);
    if (s6_onseg_q) begin
      s7_out_d.line_of_sight = on_clear;
      s7_out_d.case_code     = on_clear ? ssot_pkg::CASE_ON_CLEAR : ssot_pkg::CASE_ON_BLOCKED;
    end else begin
      s7_out_d.line_of_sight = s6_out_q;
      s7_out_d.case_code     = s6_out_q ? ssot_pkg::CASE_OFF_CLEAR : ssot_pkg::CASE_OFF_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_out_q <= s7_out_d;
    end
  end

  a_los_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_of_sight |->
      (out_data_o.case_code == ssot_pkg::CASE_ON_CLEAR ||
       out_data_o.case_code == ssot_pkg::CASE_OFF_CLEAR))
    else $error("line_of_sight set with a blocked case code");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q) && out_stall_i)
    else $error("input stalled while the pipeline has a bubble");

  a_onseg_needs_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && s4_onseg_q |-> s4_den_q != '0)
    else $error("on-segment word with zero segment length");

  a_eneg_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && s4_eneg_q |-> s4_emag_q == '0)
    else $error("negative clearance term not forced to zero");

  a_blocked_when_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] && s6_onseg_q && s6_eneg_q && en[6] |=>
      out_data_o.case_code == ssot_pkg::CASE_ON_BLOCKED)
    else $error("on-segment word with p1 inside the sphere reported clear");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for segment_sphere_occlusion_test: directed and random endpoint
// pairs over several radius settings, with an exact wide-integer predictor in a scoreboard.
// Depends on ssot_pkg and the segment_sphere_occlusion_test RTL.
module tb_top;

  localparam int    CYCLE_LIMIT = 400000;
  localparam int    HOLD_CYCLES = 80;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint CMAX = 64'sd2147483647;

  typedef logic signed [199:0] big_t;

  class occlusion_scoreboard;
    ssot_pkg::out_word_t verdicts[$];
    logic [ssot_pkg::RADIUS_W-1:0] radius;
    int unsigned errors;

    function new();
      radius = ssot_pkg::RADIUS_RESET;
      errors = 0;
    endfunction

    function void note_pair(input ssot_pkg::in_word_t w);
      big_t a[3], b[3], d[3];
      big_t p1sq, p2sq, den, num, rad, rsq, lhs, rhs;
      ssot_pkg::out_word_t v;
      a[0] = $signed(w.first_x);
      a[1] = $signed(w.first_y);
      a[2] = $signed(w.first_z);
      b[0] = $signed(w.second_x);
      b[1] = $signed(w.second_y);
      b[2] = $signed(w.second_z);
      p1sq = 0;
      p2sq = 0;
      den = 0;
      num = 0;
      for (int k = 0; k < 3; k++) begin
        d[k] = b[k] - a[k];
        p1sq += a[k] * a[k];
        p2sq += b[k] * b[k];
        den += d[k] * d[k];
        num += a[k] * d[k];
      end
      rad = radius;
      rsq = rad * rad;
      if (den > 0 && num <= 0 && -num <= den) begin
        lhs = p1sq * den;
        rhs = num * num + rsq * den;
        v.line_of_sight = (lhs >= rhs);
        v.case_code = v.line_of_sight ? ssot_pkg::CASE_ON_CLEAR : ssot_pkg::CASE_ON_BLOCKED;
      end else begin
        v.line_of_sight = (p1sq > rsq) && (p2sq > rsq);
        v.case_code = v.line_of_sight ? ssot_pkg::CASE_OFF_CLEAR : ssot_pkg::CASE_OFF_INSIDE;
      end
      verdicts.push_back(v);
    endfunction

    function void check_verdict(input ssot_pkg::out_word_t got);
      ssot_pkg::out_word_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result word, got los=%0d code=%0d", $time,
                 got.line_of_sight, got.case_code);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (got.line_of_sight !== want.line_of_sight) begin
        $display("%0t: line_of_sight mismatch, expected %0d, actual %0d", $time,
                 want.line_of_sight, got.line_of_sight);
        errors++;
      end
      if (got.case_code !== want.case_code) begin
        $display("%0t: case_code mismatch, expected %0d, actual %0d", $time,
                 want.case_code, got.case_code);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  ssot_pkg::in_word_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  ssot_pkg::out_word_t           out_data_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ssot_pkg::RADIUS_W-1:0] cfg_data_i;

  occlusion_scoreboard sb;
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit hold_req = 1'b0;
  bit next_stall;
  int hold_left = 0;
  int burst_left = 0;
  int cycle_count = 0;

  segment_sphere_occlusion_test u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check accepted words, then pick the next stall value.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_verdict(out_data_o);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        next_stall = 1'b1;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(1, 12) - 1;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall_i <= next_stall;
    end
  end

  function automatic ssot_pkg::coord_t near(input longint span);
    longint s;
    s = (span > CMAX) ? CMAX : span;
    return ssot_pkg::coord_t'(longint'($urandom_range(0, 32'(2 * s))) - s);
  endfunction

  function automatic ssot_pkg::in_word_t endpoints(input longint x1, y1, z1, x2, y2, z2);
    ssot_pkg::in_word_t w;
    w.first_x = ssot_pkg::coord_t'(x1);
    w.first_y = ssot_pkg::coord_t'(y1);
    w.first_z = ssot_pkg::coord_t'(z1);
    w.second_x = ssot_pkg::coord_t'(x2);
    w.second_y = ssot_pkg::coord_t'(y2);
    w.second_z = ssot_pkg::coord_t'(z2);
    return w;
  endfunction

  task automatic send_pair(input ssot_pkg::in_word_t w);
    int gap;
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pair(w);
  endtask

  task automatic drain();
    while (sb.verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [ssot_pkg::RADIUS_W-1:0] r);
    in_valid_i <= 1'b0;
    drain();
    repeat (ssot_pkg::NUM_STAGES + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.radius = r;
  endtask

  task automatic run_random(input int count);
    ssot_pkg::coord_t p[3], q[3], t[3];
    longint r, s, k;
    int kind, ax;
    repeat (count) begin
      r = sb.radius;
      s = 3 * r + 8;
      kind = $urandom_range(0, 99);
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        p[i] = '0;
        q[i] = '0;
      end
      if (kind < 15) begin
        for (int i = 0; i < 3; i++) begin
          p[i] = $urandom;
          q[i] = $urandom;
        end
      end else if (kind < 40) begin
        for (int i = 0; i < 3; i++) begin
          p[i] = near(s);
          q[i] = near(s);
        end
      end else if (kind < 70) begin
        k = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
          p[i] = near(s);
          q[i] = ssot_pkg::coord_t'(-longint'(p[i]) * k + longint'(near(r / 2 + 2)));
        end
      end else if (kind < 78) begin
        for (int i = 0; i < 3; i++) begin
          p[i] = near(s);
          q[i] = p[i];
        end
      end else if (kind < 86) begin
        // graze the sphere: closest point sits at distance r, give or take one
        k = ($urandom_range(0, 1) ? r : -r) + $urandom_range(0, 2) - 1;
        p[ax] = ssot_pkg::coord_t'(k);
        q[ax] = ssot_pkg::coord_t'(k);
        p[(ax + 1) % 3] = ssot_pkg::coord_t'($urandom_range(1, 1000));
        q[(ax + 1) % 3] = ssot_pkg::coord_t'(-longint'($urandom_range(0, 1000)));
      end else if (kind < 93) begin
        p[ax] = ssot_pkg::coord_t'($urandom_range(0, 1) ? r : -r);
        for (int i = 0; i < 3; i++) q[i] = near(s);
      end else begin
        for (int i = 0; i < 3; i++) q[i] = near(s);
      end
      if ($urandom_range(0, 1)) begin
        t = p;
        p = q;
        q = t;
      end
      send_pair('{p[0], p[1], p[2], q[0], q[1], q[2]});
    end
  endtask

  initial begin
    ssot_pkg::in_word_t plan[$];
    longint rr;
    logic [ssot_pkg::RADIUS_W-1:0] radii[5];
    int counts[5];

    sb = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rr = ssot_pkg::RADIUS_RESET;
    plan.push_back(endpoints(0, 0, 0, 0, 0, 0));
    plan.push_back(endpoints(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    plan.push_back(endpoints(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    plan.push_back(endpoints(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    plan.push_back(endpoints(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    plan.push_back(endpoints(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
    plan.push_back(endpoints(CMIN, 0, 0, CMAX, 0, 0));
    plan.push_back(endpoints(-rr - 1000, 0, 0, rr + 1000, 0, 0));
    plan.push_back(endpoints(-rr - 1000, rr + 1, 0, rr + 1000, rr + 1, 0));
    plan.push_back(endpoints(-5000, rr, 0, 5000, rr, 0));
    plan.push_back(endpoints(-5000, rr - 1, 0, 5000, rr - 1, 0));
    plan.push_back(endpoints(0, 0, -rr, 0, 7, rr));
    plan.push_back(endpoints(rr, 0, 0, rr + 10, 0, 0));
    plan.push_back(endpoints(rr + 1, 0, 0, rr + 10, 0, 0));
    plan.push_back(endpoints(rr + 1, 0, 0, rr + 1, 7, 0));
    plan.push_back(endpoints(rr + 1, 7, 0, rr + 1, 0, 0));
    plan.push_back(endpoints(1000000, -3, 5, 1000000, -3, 5));
    plan.push_back(endpoints(5, -3, 7, 5, -3, 7));
    plan.push_back(endpoints(0, 0, 0, 100000, 0, 0));
    plan.push_back(endpoints(100, 0, 0, 50000, 0, 0));
    plan.push_back(endpoints(1, -1, 1, -1, 1, -1));
    plan.push_back(endpoints(CMIN, CMAX, 0, 0, CMIN, CMAX));
    foreach (plan[i]) send_pair(plan[i]);

    // fill the pipe while the result side holds off
    hold_req = 1'b1;
    run_random(250);

    radii = '{ssot_pkg::RADIUS_W'(0), ssot_pkg::RADIUS_W'(1), {ssot_pkg::RADIUS_W{1'b1}},
              ssot_pkg::RADIUS_W'($urandom_range(2, 1 << 24)), ssot_pkg::RADIUS_RESET};
    counts = '{250, 200, 250, 250, 300};
    foreach (radii[i]) begin
      write_radius(radii[i]);
      if (i == 4) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      run_random(counts[i]);
    end

    in_valid_i <= 1'b0;
    drain();
    repeat (3 * ssot_pkg::NUM_STAGES) @(posedge clk_i);
    if (sb.errors == 0 && sb.verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
